>>> hdl/matrix_multiply_4x4_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiplier
// Each macro expands to a named concurrent assertion on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_4X4_DEFINES_SVH
`define MATRIX_MULTIPLY_4X4_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MM4_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("matrix multiplier: forbidden condition seen");

`define MM4_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("matrix multiplier: implication failed in the same cycle");

`define MM4_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matrix multiplier: implication failed in the next cycle");

`else

`define MM4_ASSERT_NEVER(name, cond)
`define MM4_ASSERT_SAME(name, ante, cons)
`define MM4_ASSERT_NEXT(name, ante, cons)

`endif

`endif

>>> hdl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and fixed widths of the Q16.16 matrix multiplier.
// ----------------------------------------------------------------------------
package mm4_pkg;

  localparam int EL_W   = 32;  // element width, signed Q16.16
  localparam int FRAC_W = 16;  // fractional bits
  localparam int PROD_W = 64;  // exact product of two elements

  // Tags that travel alongside the operand read data into the MAC.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

>>> hdl/mm4_mem.sv
// ----------------------------------------------------------------------------
// mm4_mem
// Operand store: one write and one registered read per cycle. A per-entry
// written flag makes unwritten entries read as zero straight after reset.
// ----------------------------------------------------------------------------
module mm4_mem
  import mm4_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  logic [EL_W-1:0] wr_data,
  input  logic [AW-1:0]   rd_addr,
  output logic [EL_W-1:0] rd_data
);

  logic [EL_W-1:0]  mem [DEPTH];
  logic [DEPTH-1:0] filled;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= filled[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[wr_addr] <= 1'b1;
    end
  end

endmodule

>>> hdl/mm4_mac.sv
// ----------------------------------------------------------------------------
// mm4_mac
// Multiply-accumulate pipeline: registered 32x32 product, exact accumulation,
// then the Q16.16 rescale with saturation to 32 bits.
// ----------------------------------------------------------------------------
module mm4_mac
  import mm4_pkg::*;
#(
  parameter int ACC_W = 66
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mac_ctl_t               ctl,
  input  logic signed [EL_W-1:0] op_a,
  input  logic signed [EL_W-1:0] op_b,
  output logic                   res_valid,
  output logic signed [EL_W-1:0] res
);

  localparam int TOP_LO = EL_W + FRAC_W - 1;

  mac_ctl_t                  prod_ctl;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic                      acc_done;
  logic                      fits;
  logic signed [EL_W-1:0]    sat_val;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (prod_ctl.valid) begin
      acc <= prod_ctl.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
    res <= sat_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl  <= '0;
      acc_done  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      prod_ctl  <= ctl;
      acc_done  <= prod_ctl.valid && prod_ctl.last;
      res_valid <= acc_done;
    end
  end

  // The sum shifted right by the fractional bits fits 32 bits exactly when
  // every bit from the top bit of the kept field upward matches the sign.
  always_comb begin
    fits = (acc[ACC_W-1:TOP_LO] == {(ACC_W-TOP_LO){acc[ACC_W-1]}});
    if (fits) begin
      sat_val = acc[TOP_LO:FRAC_W];
    end else if (acc[ACC_W-1]) begin
      sat_val = {1'b1, {(EL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(EL_W-1){1'b1}}};
    end
  end

endmodule

>>> hdl/matrix_multiply_4x4.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4
// Each input transaction stores one Q16.16 element of the left or right
// operand. With start_req set, the stored matrices are then multiplied and
// the DIM*DIM product elements leave in row-major order, last on the final.
// A product pass reads the two operand memories once per cycle while it
// issues, DIM reads per element, followed by multiply, accumulate, saturate
// and output load; the reads for the next element start only after the
// previous one has been taken at the output. No input transaction is taken
// until the last element has gone. Reset clears the written flags of both
// memories at once, so no clearing pass follows it.
// ----------------------------------------------------------------------------
`include "matrix_multiply_4x4_defines.svh"

module matrix_multiply_4x4
  import mm4_pkg::*;
#(
  parameter int DIM = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operand_select,
  input  logic [1:0]             row_index,
  input  logic [1:0]             col_index,
  input  logic signed [EL_W-1:0] element_value,
  input  logic                   start_req,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_row,
  output logic [1:0]             out_col,
  output logic signed [EL_W-1:0] product_value,
  output logic                   last
);

  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(DIM);
  localparam int ACC_W = PROD_W + $clog2(DIM);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_OUTPUT
  } state_t;

  state_t   state;
  logic [IW-1:0] r, c, k;
  logic [IW+1:0] r_ext, c_ext;
  mac_ctl_t iss_ctl;

  logic          in_acc, out_acc, idx_ok;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [EL_W-1:0] rd_a, rd_b;
  logic          res_v;
  logic signed [EL_W-1:0] res;
  logic          is_last_el;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  assign idx_ok  = (32'(row_index) < 32'(DIM)) && (32'(col_index) < 32'(DIM));
  assign wr_addr = AW'(32'(row_index) * 32'(DIM) + 32'(col_index));

  assign rd_addr_a = AW'(32'(r) * 32'(DIM) + 32'(k));
  assign rd_addr_b = AW'(32'(k) * 32'(DIM) + 32'(c));

  assign r_ext      = {2'b00, r};
  assign c_ext      = {2'b00, c};
  assign is_last_el = (r == IW'(DIM - 1)) && (c == IW'(DIM - 1));

  mm4_mem #(.DEPTH(DEPTH), .AW(AW)) u_left (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_acc && idx_ok && !operand_select),
    .wr_addr (wr_addr),
    .wr_data (element_value),
    .rd_addr (rd_addr_a),
    .rd_data (rd_a)
  );

  mm4_mem #(.DEPTH(DEPTH), .AW(AW)) u_right (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_acc && idx_ok && operand_select),
    .wr_addr (wr_addr),
    .wr_data (element_value),
    .rd_addr (rd_addr_b),
    .rd_data (rd_b)
  );

  mm4_mac #(.ACC_W(ACC_W)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (iss_ctl),
    .op_a      ($signed(rd_a)),
    .op_b      ($signed(rd_b)),
    .res_valid (res_v),
    .res       (res)
  );

  // The tags are registered so that they line up with the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      r         <= '0;
      c         <= '0;
      k         <= '0;
      iss_ctl   <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          iss_ctl <= '0;
          if (in_acc && start_req) begin
            r     <= '0;
            c     <= '0;
            k     <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          iss_ctl <= '{valid: 1'b1, first: (k == '0), last: (k == IW'(DIM - 1))};
          if (k == IW'(DIM - 1)) begin
            k     <= '0;
            state <= S_DRAIN;
          end else begin
            k <= k + IW'(1);
          end
        end
        S_DRAIN: begin
          iss_ctl <= '0;
          if (res_v) begin
            out_valid     <= 1'b1;
            product_value <= res;
            out_row       <= r_ext[1:0];
            out_col       <= c_ext[1:0];
            last          <= is_last_el;
            state         <= S_OUTPUT;
          end
        end
        S_OUTPUT: begin
          iss_ctl <= '0;
          if (out_acc) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              if (c == IW'(DIM - 1)) begin
                c <= '0;
                r <= r + IW'(1);
              end else begin
                c <= c + IW'(1);
              end
              state <= S_ISSUE;
            end
          end
        end
        default: begin
          iss_ctl <= '0;
          state   <= S_IDLE;
        end
      endcase
    end
  end

  `MM4_ASSERT_NEVER(a_no_load_while_out, in_ready && out_valid)
  `MM4_ASSERT_NEVER(a_res_only_in_drain, res_v && (state != S_DRAIN))
  `MM4_ASSERT_NEXT(a_start_blocks_input, in_acc && start_req, !in_ready)
  `MM4_ASSERT_NEXT(a_last_frees_input, out_acc && last, in_ready)
  `MM4_ASSERT_SAME(a_mac_fed_in_issue, iss_ctl.valid, $past(state) == S_ISSUE)

endmodule

>>> sim/matrix_multiply_4x4_tb.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_tb
// Loads Q16.16 operand elements into the 4x4 multiplier and requests products.
// Each product element is checked against a local fixed-point predictor. The
// run uses random gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_tb;
  import mm4_pkg::*;

  localparam int DIM         = 4;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 130;

  typedef struct {
    logic [1:0]             row;
    logic [1:0]             col;
    logic signed [EL_W-1:0] value;
    logic                   last;
  } product_elem_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   operand_select = 1'b0;
  logic [1:0]             row_index = '0;
  logic [1:0]             col_index = '0;
  logic signed [EL_W-1:0] element_value = '0;
  logic                   start_req = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             out_row;
  logic [1:0]             out_col;
  logic signed [EL_W-1:0] product_value;
  logic                   last;

  logic signed [EL_W-1:0] left_store [DIM][DIM] = '{default: '0};
  logic signed [EL_W-1:0] right_store [DIM][DIM] = '{default: '0};
  product_elem_t          pending_products [$];
  product_elem_t          oldest;

  int  fail_count = 0;
  int  items_sent = 0;
  int  products_requested = 0;
  int  elements_checked = 0;
  int  cycle_count = 0;
  int  ready_hold = 0;
  bit  no_stall = 1'b0;

  matrix_multiply_4x4 uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operand_select (operand_select),
    .row_index      (row_index),
    .col_index      (col_index),
    .element_value  (element_value),
    .start_req      (start_req),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .product_value  (product_value),
    .last           (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact 64-bit products summed without loss, floored by 16 bits, saturated.
  function automatic logic signed [EL_W-1:0] predict_product(int r, int c);
    logic signed [67:0] acc;
    logic signed [63:0] term;
    logic signed [67:0] shifted;
    acc = '0;
    for (int k = 0; k < DIM; k++) begin
      term = left_store[r][k] * right_store[k][c];
      acc = acc + term;
    end
    shifted = acc >>> FRAC_W;
    if (shifted > 68'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (shifted < -68'sh0_8000_0000) return 32'sh8000_0000;
    return shifted[EL_W-1:0];
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (no_stall) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [EL_W-1:0] random_element();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      6:       return {{12{$urandom_range(0, 1) == 1}}, 4'($urandom), 16'($urandom)};
      7:       return 32'sh7FFF_FFFF;
      8:       return 32'sh8000_0000;
      default: return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
    endcase
  endfunction

  // Sends one element. Valid stays high into the next call when no gap follows.
  task automatic send_element(input logic sel, input logic [1:0] r, input logic [1:0] c,
                              input logic signed [EL_W-1:0] v, input logic go);
    product_elem_t elem;
    int gap;
    in_valid       <= 1'b1;
    operand_select <= sel;
    row_index      <= r;
    col_index      <= c;
    element_value  <= v;
    start_req      <= go;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (sel) right_store[r][c] = v;
    else left_store[r][c] = v;
    if (go) begin
      products_requested++;
      for (int pr = 0; pr < DIM; pr++) begin
        for (int pc = 0; pc < DIM; pc++) begin
          elem.row   = pr[1:0];
          elem.col   = pc[1:0];
          elem.value = predict_product(pr, pc);
          elem.last  = (pr == DIM - 1) && (pc == DIM - 1);
          pending_products.push_back(elem);
        end
      end
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  // A product straight after reset must be all zero: the left matrix is clear.
  task automatic test_reset_state();
    send_element(1'b1, 2'd3, 2'd3, random_element(), 1'b1);
    wait_drained();
  endtask

  // Full-scale operands drive the sums past both ends of the 32-bit range.
  task automatic test_saturation();
    for (int k = 0; k < DIM; k++) send_element(1'b0, 2'd0, k[1:0], 32'sh8000_0000, 1'b0);
    for (int k = 0; k < DIM; k++)
      send_element(1'b1, k[1:0], 2'd0, 32'sh8000_0000, k == DIM - 1);
    send_element(1'b1, 2'd0, 2'd0, 32'sh7FFF_FFFF, 1'b1);
    for (int k = 1; k < DIM; k++)
      send_element(1'b1, k[1:0], 2'd0, 32'sh7FFF_FFFF, k == DIM - 1);
    wait_drained();
  endtask

  // A product of minus one LSB must floor to minus one, not round to zero.
  task automatic test_floor_rounding();
    send_element(1'b0, 2'd1, 2'd0, -32'sd1, 1'b0);
    send_element(1'b1, 2'd0, 2'd1, 32'sd1, 1'b1);
    send_element(1'b0, 2'd2, 2'd3, 32'sh0001_8000, 1'b0);
    send_element(1'b1, 2'd3, 2'd2, -32'sh0000_8001, 1'b1);
    wait_drained();
  endtask

  // Short load sequences ending in a product request, with some noise.
  task automatic test_random_sequences(input int target);
    int loads;
    while (items_sent < target) begin
      case ($urandom_range(0, 19))
        0:       loads = 2 * DIM * DIM - 1;
        1, 2, 3: loads = 0;
        default: loads = $urandom_range(1, 6);
      endcase
      repeat (loads)
        send_element(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)), random_element(), 1'b0);
      send_element(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), random_element(), 1'b1);
    end
    wait_drained();
  endtask

  // Neither side idles here, so transactions run back to back.
  task automatic test_back_to_back();
    no_stall = 1'b1;
    repeat (3) begin
      repeat (3)
        send_element(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)), random_element(), 1'b0);
      send_element(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   2'($urandom_range(0, 3)), random_element(), 1'b1);
    end
    wait_drained();
    no_stall = 1'b0;
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      out_ready  <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_stall) ready_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        $error("product element with no request outstanding: row %0d col %0d value %0h",
               out_row, out_col, product_value);
        fail_count++;
      end else begin
        oldest = pending_products.pop_front();
        elements_checked++;
        if (out_row !== oldest.row) begin
          $error("out_row: expected %0d, got %0d", oldest.row, out_row);
          fail_count++;
        end
        if (out_col !== oldest.col) begin
          $error("out_col: expected %0d, got %0d", oldest.col, out_col);
          fail_count++;
        end
        if (product_value !== oldest.value) begin
          $error("product_value: expected %0h, got %0h", oldest.value, product_value);
          fail_count++;
        end
        if (last !== oldest.last) begin
          $error("last: expected %0b, got %0b", oldest.last, last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out with %0d product elements outstanding.", pending_products.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_saturation();
    test_floor_rounding();
    test_back_to_back();
    test_random_sequences(ITEM_TARGET);
    repeat (200) @(posedge clk);
    $display("Sent %0d transactions with %0d product requests; checked %0d elements.",
             items_sent, products_requested, elements_checked);
    $display("Covered reset state, saturation both ways, floor rounding and random loads.");
    if (fail_count == 0 && pending_products.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/mm4_pkg.sv
hdl/mm4_mem.sv
hdl/mm4_mac.sv
hdl/matrix_multiply_4x4.sv
sim/matrix_multiply_4x4_tb.sv
